[rtl/decimal_text_to_double_defines.svh]
// Assertion macros shared by the RTL of the decimal text to double converter.
// No dependencies; files that check their own logic include this header.
`ifndef DECIMAL_TEXT_TO_DOUBLE_DEFINES_SVH
`define DECIMAL_TEXT_TO_DOUBLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEVER(lbl, clk, rst, cond)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/dtd_pkg.sv]
// Types, codes and floating-point helpers of the decimal text to double converter.
// No dependencies; used by every module of the block.
`default_nettype none

package dtd_pkg;

  localparam int MaxMantDigits = 18;
  localparam int MaxDecExp     = 511;
  localparam int CntMax        = 4095;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NAN   = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [29:0] BILLION   = 30'd1_000_000_000;

  typedef enum logic [2:0] {
    PH_SKIP, PH_MANT, PH_ESIGN, PH_EDIG, PH_DONE, PH_BAD
  } phase_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SPLIT, B_NORM, B_RND, B_UNSHIFT, B_POW, B_MUL, B_MRND,
    B_FINAL, B_DIV, B_DNORM, B_DSUB, B_OUT
  } back_state_t;

  // One parsed number as handed from the parser to the arithmetic sequencer.
  typedef struct packed {
    logic        nan;
    logic        neg;
    logic        zero;
    logic [29:0] hi;
    logic [29:0] lo;
    logic        eneg;
    logic [8:0]  mag;
    logic        clamp;
  } num_req_t;

  // Bit patterns of 10^(2^i).
  function automatic logic [63:0] pow_bits(input logic [3:0] i);
    logic [63:0] r;
    case (i)
      4'd0:    r = 64'h4024_0000_0000_0000;
      4'd1:    r = 64'h4059_0000_0000_0000;
      4'd2:    r = 64'h40C3_8800_0000_0000;
      4'd3:    r = 64'h4197_D784_0000_0000;
      4'd4:    r = 64'h4341_C379_37E0_8000;
      4'd5:    r = 64'h4693_B8B5_B505_6E17;
      4'd6:    r = 64'h4D38_4F03_E93F_F9F5;
      4'd7:    r = 64'h5A82_7748_F930_1D32;
      4'd8:    r = 64'h7515_4FDD_7F73_BF3C;
      default: r = 64'h3FF0_0000_0000_0000;
    endcase
    return r;
  endfunction

  // Rounds to nearest even and packs a positive value. A significand whose top
  // bit is clear is taken as subnormal; a rounding carry moves into the exponent.
  function automatic logic [63:0] fp_pack(input logic signed [12:0] e,
                                          input logic [52:0] s,
                                          input logic g,
                                          input logic st);
    logic [10:0] ef;
    logic [63:0] base;
    logic        rnd;
    logic [63:0] r;
    ef   = s[52] ? 11'(e + 13'sd1023) : 11'd0;
    base = {1'b0, ef, s[51:0]};
    rnd  = g & (st | s[0]);
    if (e > 13'sd1023) begin
      r = INF_BITS;
    end else begin
      r = base + 64'(rnd);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/decimal_text_to_double.sv]
// Decimal text to IEEE double converter. Bytes are taken at one per cycle while
// the request queue has room; for each number the sequencer forms the fraction,
// then does the power-of-ten multiplies and the final multiply or divide.
// Synchronous reset clears the parser, the two-entry queue, the sequencer and the
// result valid flag.
`default_nettype none

module decimal_text_to_double (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      value_bits,
  output logic [1:0]       status
);
  import dtd_pkg::*;

  num_req_t q_din, q_dout;
  logic     q_push, q_pop, q_full, q_empty;

  assign full = q_full;

  dtd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .ch     (ch),
    .last   (last),
    .q_full (q_full),
    .q_push (q_push),
    .q_din  (q_din)
  );

  dtd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  dtd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_dout     (q_dout),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .value_bits (value_bits),
    .status     (status)
  );

endmodule

`default_nettype wire

[rtl/dtd_front.sv]
// Character parser: takes one byte per cycle while the queue is not full and emits a parsed number record.
// Depends on dtd_pkg.
`default_nettype none

module dtd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [7:0]        ch,
  input  wire logic              last,
  input  wire logic              q_full,
  output logic                   q_push,
  output dtd_pkg::num_req_t      q_din
);
  import dtd_pkg::*;

  phase_t      phase, phase_next;
  logic        negative, negative_next;
  logic        point_seen, point_seen_next;
  logic [11:0] digit_count, digit_count_next;
  logic [11:0] digits_before_point, digits_before_point_next;
  logic [59:0] mantissa_value, mantissa_value_next;
  logic [29:0] mant_hi, mant_hi_next;
  logic [29:0] mant_lo, mant_lo_next;
  logic        exponent_negative, exponent_negative_next;
  logic [11:0] exponent_value, exponent_value_next;

  logic        accept, is_dig, is_sp, take_dig, take_exp;
  logic [3:0]  digit;
  logic [15:0] exp_mul;
  logic [33:0] lo_x10, hi_x10, lo_sub;
  logic [3:0]  lo_carry;
  logic [4:0]  kept;
  logic signed [13:0] e_base, e_tot;
  logic [13:0] e_mag;
  logic        clamp;

  assign accept = push & ~q_full;
  assign is_dig = ch inside {[8'h30:8'h39]};
  assign is_sp  = ch inside {8'h20, [8'h09:8'h0D]};
  assign digit  = 4'(ch - CH_ZERO);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SKIP: begin
        if (is_sp) begin
          phase_next = PH_SKIP;
        end else if (is_dig || ch == CH_MINUS || ch == CH_PLUS || ch == CH_POINT) begin
          phase_next = PH_MANT;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_MANT: begin
        if (is_dig || (ch == CH_POINT && !point_seen)) begin
          phase_next = PH_MANT;
        end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
          phase_next = PH_ESIGN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_ESIGN: begin
        if (is_dig || ch == CH_MINUS || ch == CH_PLUS) begin
          phase_next = PH_EDIG;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_EDIG: begin
        if (!is_dig) begin
          phase_next = PH_DONE;
        end
      end
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    take_dig = is_dig && (phase == PH_SKIP || phase == PH_MANT);
    take_exp = is_dig && (phase == PH_ESIGN || phase == PH_EDIG);
    negative_next   = negative | (phase == PH_SKIP && ch == CH_MINUS);
    point_seen_next = point_seen |
                      ((phase == PH_SKIP || phase == PH_MANT) && ch == CH_POINT);
    exponent_negative_next = exponent_negative | (phase == PH_ESIGN && ch == CH_MINUS);

    // The kept digits are also carried as high and low nine-digit parts: the
    // decimal digit that leaves the low part moves into the high part.
    lo_x10   = {1'b0, mant_lo, 3'b0} + {3'b0, mant_lo, 1'b0} + 34'(digit);
    lo_carry = 4'd0;
    lo_sub   = 34'd0;
    for (int k = 1; k <= 9; k++) begin
      if (lo_x10 >= 34'(k) * {4'd0, BILLION}) begin
        lo_carry = 4'(k);
        lo_sub   = 34'(k) * {4'd0, BILLION};
      end
    end
    hi_x10 = {1'b0, mant_hi, 3'b0} + {3'b0, mant_hi, 1'b0} + 34'(lo_carry);

    digit_count_next = digit_count;
    mantissa_value_next = mantissa_value;
    mant_hi_next = mant_hi;
    mant_lo_next = mant_lo;
    digits_before_point_next = digits_before_point;
    if (take_dig) begin
      if (digit_count != 12'(CntMax)) begin
        digit_count_next = digit_count + 12'd1;
      end
      if (digit_count < 12'(MaxMantDigits)) begin
        mantissa_value_next = (mantissa_value << 3) + (mantissa_value << 1) + 60'(digit);
        mant_lo_next = 30'(lo_x10 - lo_sub);
        mant_hi_next = hi_x10[29:0];
      end
      if (!point_seen && digits_before_point != 12'(CntMax)) begin
        digits_before_point_next = digits_before_point + 12'd1;
      end
    end

    exp_mul = 16'({exponent_value, 3'b0}) + 16'({exponent_value, 1'b0}) + 16'(digit);
    exponent_value_next = exponent_value;
    if (take_exp) begin
      exponent_value_next = (exp_mul > 16'(CntMax)) ? 12'(CntMax) : exp_mul[11:0];
    end

    // Decimal exponent of the kept digits, folded to sign and magnitude.
    kept   = (digit_count_next < 12'(MaxMantDigits)) ? digit_count_next[4:0]
                                                     : 5'(MaxMantDigits);
    e_base = $signed({2'b0, digits_before_point_next}) - $signed({9'b0, kept});
    e_tot  = exponent_negative_next ? e_base - $signed({2'b0, exponent_value_next})
                                    : e_base + $signed({2'b0, exponent_value_next});
    e_mag  = e_tot[13] ? 14'(-e_tot) : 14'(e_tot);
    clamp  = (digit_count_next != 12'd0) && (e_mag > 14'(MaxDecExp));

    q_din.nan   = (phase_next == PH_SKIP) || (phase_next == PH_BAD);
    q_din.neg   = negative_next;
    q_din.zero  = (digit_count_next == 12'd0) || (mantissa_value_next == 60'd0);
    q_din.hi    = mant_hi_next;
    q_din.lo    = mant_lo_next;
    q_din.eneg  = e_tot[13];
    q_din.mag   = clamp ? 9'(MaxDecExp) : e_mag[8:0];
    q_din.clamp = clamp;
    q_push      = accept & last;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase               <= PH_SKIP;
      negative            <= 1'b0;
      point_seen          <= 1'b0;
      digit_count         <= 12'd0;
      digits_before_point <= 12'd0;
      mantissa_value      <= 60'd0;
      mant_hi             <= 30'd0;
      mant_lo             <= 30'd0;
      exponent_negative   <= 1'b0;
      exponent_value      <= 12'd0;
    end else if (accept) begin
      phase               <= phase_next;
      negative            <= negative_next;
      point_seen          <= point_seen_next;
      digit_count         <= digit_count_next;
      digits_before_point <= digits_before_point_next;
      mantissa_value      <= mantissa_value_next;
      mant_hi             <= mant_hi_next;
      mant_lo             <= mant_lo_next;
      exponent_negative   <= exponent_negative_next;
      exponent_value      <= exponent_value_next;
    end
  end

endmodule

`default_nettype wire

[rtl/dtd_queue.sv]
// Two-entry queue of parsed number requests between parser and sequencer.
// Depends on dtd_pkg and the assertion macro header.
`default_nettype none
`include "decimal_text_to_double_defines.svh"

module dtd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dtd_pkg::num_req_t din,
  input  wire logic              pop,
  output dtd_pkg::num_req_t      dout,
  output logic                   full,
  output logic                   empty
);
  import dtd_pkg::*;

  num_req_t   mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count == 2'd3)
  `ASSERT_IMPL(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPL(a_no_underflow, clk, rst, pop, !empty)

endmodule

`default_nettype wire

[rtl/dtd_back.sv]
// Arithmetic sequencer: builds the double from a parsed request with shared
// serial multiply and divide steps, and holds the result register. Uses dtd_pkg.
`default_nettype none

module dtd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtd_pkg::num_req_t q_dout,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [63:0]            value_bits,
  output logic [1:0]             status
);
  import dtd_pkg::*;

  back_state_t state, state_next;
  num_req_t    rec;
  logic [5:0]  cnt;
  logic [29:0] lo;
  logic [61:0] acc;
  logic [5:0]  n;
  logic        pass;
  logic signed [12:0] frac_e, pw_e, me, de;
  logic [52:0] frac_s, pw_s, ma, mb, dsig;
  logic        pw_inf, final_op, dg, dst;
  logic [3:0]  idx;
  logic [105:0] prod;
  logic [55:0] dq;
  logic [54:0] drem;
  logic [63:0] res;
  logic        out_valid;

  logic [59:0] hi_prod;
  logic [53:0] rsum;
  logic [63:0] tab_bits, mbits;
  logic signed [12:0] tab_e;
  logic [53:0] mul_sum;
  logic        div_ge;
  logic [54:0] div_diff;
  logic        slot_free;

  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;

  always_comb begin
    hi_prod  = {30'd0, rec.hi} * {30'd0, BILLION};
    rsum     = {1'b0, acc[61:9]} + 54'(acc[8] & ((|acc[7:0]) | acc[9]));
    tab_bits = pow_bits(idx);
    tab_e    = $signed({2'b0, tab_bits[62:52]}) - 13'sd1023;
    mul_sum  = {1'b0, prod[105:53]} + (mb[0] ? {1'b0, ma} : 54'd0);
    div_ge   = drem >= {2'b0, pw_s};
    div_diff = drem - {2'b0, pw_s};
    if (prod[105]) begin
      mbits = fp_pack(me + 13'sd1, prod[105:53], prod[52], |prod[51:0]);
    end else begin
      mbits = fp_pack(me, prod[104:52], prod[51], |prod[50:0]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_dout.nan || q_dout.zero) ? B_OUT : B_SPLIT;
        end
      end
      B_SPLIT:   state_next = B_NORM;
      B_NORM:    if (acc == 62'd0 || acc[61]) state_next = B_RND;
      B_RND:     state_next = B_UNSHIFT;
      B_UNSHIFT: begin
        if (pass) begin
          state_next = B_POW;
        end else if (n == 6'd0) begin
          state_next = B_NORM;
        end
      end
      B_POW: begin
        if (idx == 4'd9) begin
          state_next = B_FINAL;
        end else if (rec.mag[idx] && !pw_inf) begin
          state_next = B_MUL;
        end
      end
      B_MUL:  if (cnt == 6'd52) state_next = B_MRND;
      B_MRND: state_next = final_op ? B_OUT : B_POW;
      B_FINAL: begin
        if (pw_inf) begin
          state_next = B_OUT;
        end else begin
          state_next = rec.eneg ? B_DIV : B_MUL;
        end
      end
      B_DIV:   if (cnt == 6'd55) state_next = B_DNORM;
      B_DNORM: state_next = B_DSUB;
      B_DSUB:  if (de >= -13'sd1022) state_next = B_OUT;
      B_OUT:   if (slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        rec  <= q_dout;
        cnt  <= 6'd0;
        res  <= 64'd0;
      end
      B_SPLIT: begin
        // The high nine-digit part is scaled by one billion here; the low part
        // is added once that product has been rounded to a double.
        lo   <= rec.lo;
        acc  <= {2'b0, hi_prod};
        n    <= 6'd0;
        pass <= 1'b0;
      end
      B_NORM: begin
        if (acc != 62'd0 && !acc[61]) begin
          acc <= {acc[60:0], 1'b0};
          n   <= n + 6'd1;
        end
      end
      B_RND: begin
        if (rsum[53]) begin
          acc <= {1'b1, 61'd0};
          n   <= n - 6'd1;
        end else begin
          acc <= {rsum[52:0], 9'd0};
        end
      end
      B_UNSHIFT: begin
        if (pass) begin
          frac_s <= acc[61:9];
          frac_e <= 13'sd61 - $signed({7'b0, n});
          pw_s   <= {1'b1, 52'd0};
          pw_e   <= 13'sd0;
          pw_inf <= 1'b0;
          idx    <= 4'd0;
        end else if (n != 6'd0) begin
          acc <= {1'b0, acc[61:1]};
          n   <= n - 6'd1;
        end else begin
          // The high part is rounded to a double before the low part is added.
          acc  <= acc + {32'b0, lo};
          pass <= 1'b1;
        end
      end
      B_POW: begin
        if (idx != 4'd9) begin
          if (rec.mag[idx] && !pw_inf) begin
            ma       <= pw_s;
            mb       <= {1'b1, tab_bits[51:0]};
            me       <= pw_e + tab_e;
            prod     <= 106'd0;
            cnt      <= 6'd0;
            final_op <= 1'b0;
          end else begin
            idx <= idx + 4'd1;
          end
        end
      end
      B_MUL: begin
        prod <= {mul_sum, prod[52:1]};
        mb   <= {1'b0, mb[52:1]};
        cnt  <= cnt + 6'd1;
      end
      B_MRND: begin
        if (final_op) begin
          res <= mbits;
        end else begin
          pw_inf <= (mbits[62:52] == 11'h7FF);
          pw_e   <= $signed({2'b0, mbits[62:52]}) - 13'sd1023;
          pw_s   <= {1'b1, mbits[51:0]};
          idx    <= idx + 4'd1;
        end
      end
      B_FINAL: begin
        cnt <= 6'd0;
        if (pw_inf) begin
          res <= rec.eneg ? 64'd0 : INF_BITS;
        end else if (rec.eneg) begin
          drem <= {2'b0, frac_s};
          dq   <= 56'd0;
          de   <= frac_e - pw_e;
        end else begin
          ma       <= frac_s;
          mb       <= pw_s;
          me       <= frac_e + pw_e;
          prod     <= 106'd0;
          final_op <= 1'b1;
        end
      end
      B_DIV: begin
        dq   <= {dq[54:0], div_ge};
        drem <= div_ge ? {div_diff[53:0], 1'b0} : {drem[53:0], 1'b0};
        cnt  <= cnt + 6'd1;
      end
      B_DNORM: begin
        if (dq[55]) begin
          dsig <= dq[55:3];
          dg   <= dq[2];
          dst  <= (|dq[1:0]) | (drem != 55'd0);
        end else begin
          dsig <= dq[54:2];
          dg   <= dq[1];
          dst  <= dq[0] | (drem != 55'd0);
          de   <= de - 13'sd1;
        end
      end
      B_DSUB: begin
        // Quotients below the normal range are shifted down to subnormal form.
        if (de < -13'sd1022) begin
          dst  <= dst | dg;
          dg   <= dsig[0];
          dsig <= {1'b0, dsig[52:1]};
          de   <= de + 13'sd1;
        end else begin
          res <= fp_pack(de, dsig, dg, dst);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && slot_free) begin
      value_bits <= rec.nan ? QNAN_BITS : {rec.neg, res[62:0]};
      status     <= rec.nan ? ST_NAN : (rec.clamp ? ST_CLAMP : ST_OK);
    end
  end

endmodule

`default_nettype wire
